// ===== src/thvf_pkg.sv =====
// Shared types, constants and register map of the thermal/visible YUV fusion block.
`default_nettype none

package thvf_pkg;

    localparam int COEF_FRAC_BITS_DEF = 8;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int PIX_W   = 8;
    localparam int GAIN_W  = 10;
    localparam int OFF_W   = 10;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int IDX_W   = APB_AW - 2;

    localparam logic [GAIN_W-1:0]       GAIN_RST = 10'd256;
    localparam logic [PIX_W-1:0]        PIX_MAX  = 8'd255;
    localparam logic signed [OFF_W-1:0] OFF_HF   = 10'sd128;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_CAM_Y_GAIN = 3'd1,
        REG_CAM_C_GAIN = 3'd2,
        REG_TH_Y_GAIN  = 3'd3,
        REG_TH_C_GAIN  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              hf_mode;
        logic [GAIN_W-1:0] cam_y_gain;
        logic [GAIN_W-1:0] cam_c_gain;
        logic [GAIN_W-1:0] th_y_gain;
        logic [GAIN_W-1:0] th_c_gain;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] cam_y;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             chroma;
        logic [PIX_W-1:0] cam_v;
        logic [PIX_W-1:0] cam_u;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] cam_y;
        logic [PIX_W-1:0] cam_v;
        logic [PIX_W-1:0] cam_u;
        logic             chroma;
    } side_t;

    typedef struct packed {
        side_t                    side;
        logic signed [OFF_W-1:0]  y_off;
        logic signed [OFF_W-1:0]  v_off;
        logic signed [OFF_W-1:0]  u_off;
    } offs_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic             chroma;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] u;
    } fused_t;

endpackage

`default_nettype wire

// ===== src/thermal_visible_yuv_fusion.sv =====
// Top level of the thermal/visible YUV fusion block.
// One pixel beat is accepted per clock when the output side does not stall, and
// one fused beat leaves per pixel after passing through three stages of
// BT.601 color conversion (coefficient products, sums, scaling to offsets), then
// a gain-product stage and a sum/clamp stage that is the output register. Each
// stage holds its data only while the next one is full and stalled, so bubbles
// close up and s_tready stays high as long as any stage can move. Chroma is
// produced only on beats with s_tuser set; other beats leave fused U and V at
// zero. In high-frequency mode the camera gains act as zero. Registers may be
// changed only while no beat is in flight.
`default_nettype none

module thermal_visible_yuv_fusion import thvf_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // camera_luma, thermal_blue, thermal_green, thermal_red, camera_v, camera_u
    input  wire logic [47:0]       s_tdata,
    // chroma_sample
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // fused_luma, fused_v, fused_u
    output logic [23:0]            m_tdata,
    // chroma_out_valid
    output logic                   m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    cfg_t   cfg;
    pix_t   in_pix;
    offs_t  offs;
    logic   offs_valid, offs_ready;
    fused_t out_pix;

    assign in_pix.cam_y  = s_tdata[7:0];
    assign in_pix.blue   = s_tdata[15:8];
    assign in_pix.green  = s_tdata[23:16];
    assign in_pix.red    = s_tdata[31:24];
    assign in_pix.chroma = s_tuser;
    assign in_pix.cam_v  = s_tdata[39:32];
    assign in_pix.cam_u  = s_tdata[47:40];

    thvf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    thvf_csc #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_csc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hf_mode   (cfg.hf_mode),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .out_valid (offs_valid),
        .out_ready (offs_ready),
        .out_offs  (offs)
    );

    thvf_blend #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (offs_valid),
        .in_ready  (offs_ready),
        .in_offs   (offs),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix.u, out_pix.v, out_pix.luma};
    assign m_tuser = out_pix.chroma;

endmodule

`default_nettype wire

// ===== src/thvf_regs.sv =====
// APB configuration registers: mode and the four blend gains.
`default_nettype none

module thvf_regs import thvf_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hf_mode    <= 1'b0;
            cfg_reg.cam_y_gain <= GAIN_RST;
            cfg_reg.cam_c_gain <= GAIN_RST;
            cfg_reg.th_y_gain  <= GAIN_RST;
            cfg_reg.th_c_gain  <= GAIN_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:       cfg_reg.hf_mode    <= pwdata[0];
                REG_CAM_Y_GAIN: cfg_reg.cam_y_gain <= pwdata[GAIN_W-1:0];
                REG_CAM_C_GAIN: cfg_reg.cam_c_gain <= pwdata[GAIN_W-1:0];
                REG_TH_Y_GAIN:  cfg_reg.th_y_gain  <= pwdata[GAIN_W-1:0];
                REG_TH_C_GAIN:  cfg_reg.th_c_gain  <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:       prdata = APB_DW'(cfg_reg.hf_mode);
            REG_CAM_Y_GAIN: prdata = APB_DW'(cfg_reg.cam_y_gain);
            REG_CAM_C_GAIN: prdata = APB_DW'(cfg_reg.cam_c_gain);
            REG_TH_Y_GAIN:  prdata = APB_DW'(cfg_reg.th_y_gain);
            REG_TH_C_GAIN:  prdata = APB_DW'(cfg_reg.th_c_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/thvf_csc.sv =====
// Three-stage BT.601 conversion of the thermal color into signed YUV offsets.
`default_nettype none

module thvf_csc import thvf_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic hf_mode,
    input  wire logic in_valid,
    output logic      in_ready,
    input  pix_t      in_pix,
    output logic      out_valid,
    input  wire logic out_ready,
    output offs_t     out_offs
);

    localparam int CW = COEF_FRAC_BITS;
    localparam int PW = CW + PIX_W;
    localparam int SW = PW + 2;

    localparam int CQ_YR = (257 * (1 << CW) + 500) / 1000;
    localparam int CQ_YG = (504 * (1 << CW) + 500) / 1000;
    localparam int CQ_YB = (98  * (1 << CW) + 500) / 1000;
    localparam int CQ_UR = (148 * (1 << CW) + 500) / 1000;
    localparam int CQ_UG = (291 * (1 << CW) + 500) / 1000;
    localparam int CQ_UB = (439 * (1 << CW) + 500) / 1000;
    localparam int CQ_VR = (439 * (1 << CW) + 500) / 1000;
    localparam int CQ_VG = (368 * (1 << CW) + 500) / 1000;
    localparam int CQ_VB = (71  * (1 << CW) + 500) / 1000;

    localparam logic [PW-1:0] K_YR = PW'(CQ_YR);
    localparam logic [PW-1:0] K_YG = PW'(CQ_YG);
    localparam logic [PW-1:0] K_YB = PW'(CQ_YB);
    localparam logic [PW-1:0] K_UR = PW'(CQ_UR);
    localparam logic [PW-1:0] K_UG = PW'(CQ_UG);
    localparam logic [PW-1:0] K_UB = PW'(CQ_UB);
    localparam logic [PW-1:0] K_VR = PW'(CQ_VR);
    localparam logic [PW-1:0] K_VG = PW'(CQ_VG);
    localparam logic [PW-1:0] K_VB = PW'(CQ_VB);

    localparam logic signed [SW-1:0] Y_BIAS = SW'(112 << CW);
    localparam logic signed [SW-1:0] RND    = SW'((1 << CW) - 1);

    // divide by 2^CW toward zero, then the high-frequency lift
    function automatic logic signed [OFF_W-1:0] tdiv(input logic signed [SW-1:0] s,
                                                     input logic hf);
        logic signed [SW-1:0] adj;
        adj  = s + (s[SW-1] ? RND : '0);
        tdiv = OFF_W'(adj >>> CW) + (hf ? OFF_HF : '0);
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    side_t         side1_reg, side2_reg;
    logic [PW-1:0] p_yr_reg, p_yg_reg, p_yb_reg;
    logic [PW-1:0] p_ur_reg, p_ug_reg, p_ub_reg;
    logic [PW-1:0] p_vr_reg, p_vg_reg, p_vb_reg;

    logic signed [SW-1:0] y_sum_next, u_sum_next, v_sum_next;
    logic signed [SW-1:0] y_sum_reg,  u_sum_reg,  v_sum_reg;

    offs_t offs_next, offs_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 1: coefficient products
    always_ff @(posedge aclk) begin
        if (en1) begin
            side1_reg.cam_y  <= in_pix.cam_y;
            side1_reg.cam_v  <= in_pix.cam_v;
            side1_reg.cam_u  <= in_pix.cam_u;
            side1_reg.chroma <= in_pix.chroma;
            p_yr_reg <= K_YR * PW'(in_pix.red);
            p_yg_reg <= K_YG * PW'(in_pix.green);
            p_yb_reg <= K_YB * PW'(in_pix.blue);
            p_ur_reg <= K_UR * PW'(in_pix.red);
            p_ug_reg <= K_UG * PW'(in_pix.green);
            p_ub_reg <= K_UB * PW'(in_pix.blue);
            p_vr_reg <= K_VR * PW'(in_pix.red);
            p_vg_reg <= K_VG * PW'(in_pix.green);
            p_vb_reg <= K_VB * PW'(in_pix.blue);
        end
    end

    // stage 2: weighted sums
    always_comb begin
        y_sum_next = $signed(SW'(p_yr_reg)) + $signed(SW'(p_yg_reg))
                   + $signed(SW'(p_yb_reg)) - Y_BIAS;
        u_sum_next = $signed(SW'(p_ub_reg)) - $signed(SW'(p_ur_reg))
                   - $signed(SW'(p_ug_reg));
        v_sum_next = $signed(SW'(p_vr_reg)) - $signed(SW'(p_vg_reg))
                   - $signed(SW'(p_vb_reg));
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            side2_reg <= side1_reg;
            y_sum_reg <= y_sum_next;
            u_sum_reg <= u_sum_next;
            v_sum_reg <= v_sum_next;
        end
    end

    // stage 3: scale down to offsets
    always_comb begin
        offs_next.side  = side2_reg;
        offs_next.y_off = tdiv(y_sum_reg, hf_mode);
        offs_next.v_off = tdiv(v_sum_reg, hf_mode);
        offs_next.u_off = tdiv(u_sum_reg, hf_mode);
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            offs_reg <= offs_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_offs  = offs_reg;

endmodule

`default_nettype wire

// ===== src/thvf_blend.sv =====
// Two-stage gain blend of camera samples with thermal offsets, clamped to 8 bits.
`default_nettype none

module thvf_blend import thvf_pkg::*; #(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic in_valid,
    output logic      in_ready,
    input  offs_t     in_offs,
    output logic      out_valid,
    input  wire logic out_ready,
    output fused_t    out_pix
);

    localparam int CPW = PIX_W + GAIN_W;
    localparam int TPW = OFF_W + GAIN_W + 1;
    localparam int AW  = TPW + 1;

    function automatic logic [PIX_W-1:0] clamp(input logic [CPW-1:0] cp,
                                               input logic signed [TPW-1:0] tp);
        logic signed [AW-1:0] acc;
        logic [AW-1:0]        q;
        acc = $signed(AW'(cp)) + AW'(tp);
        q   = AW'(acc >>> GAIN_FRAC_BITS);
        if (acc[AW-1]) begin
            clamp = '0;
        end else if (q > AW'(PIX_MAX)) begin
            clamp = PIX_MAX;
        end else begin
            clamp = q[PIX_W-1:0];
        end
    endfunction

    logic va_reg, vb_reg;
    logic ena, enb;

    logic [GAIN_W-1:0] gy, guv;

    logic                  chroma_a_reg;
    logic [CPW-1:0]        cy_p_reg, cv_p_reg, cu_p_reg;
    logic signed [TPW-1:0] ty_p_reg, tv_p_reg, tu_p_reg;

    fused_t pix_next, pix_reg;

    assign enb      = !vb_reg || out_ready;
    assign ena      = !va_reg || enb;
    assign in_ready = ena;

    assign gy  = cfg.hf_mode ? '0 : cfg.cam_y_gain;
    assign guv = cfg.hf_mode ? '0 : cfg.cam_c_gain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (ena) va_reg <= in_valid;
            if (enb) vb_reg <= va_reg;
        end
    end

    // stage A: gain products
    always_ff @(posedge aclk) begin
        if (ena) begin
            chroma_a_reg <= in_offs.side.chroma;
            cy_p_reg <= CPW'(in_offs.side.cam_y) * CPW'(gy);
            cv_p_reg <= CPW'(in_offs.side.cam_v) * CPW'(guv);
            cu_p_reg <= CPW'(in_offs.side.cam_u) * CPW'(guv);
            ty_p_reg <= TPW'(in_offs.y_off) * $signed(TPW'(cfg.th_y_gain));
            tv_p_reg <= TPW'(in_offs.v_off) * $signed(TPW'(cfg.th_c_gain));
            tu_p_reg <= TPW'(in_offs.u_off) * $signed(TPW'(cfg.th_c_gain));
        end
    end

    // stage B: sum, scale and clamp
    always_comb begin
        pix_next.luma   = clamp(cy_p_reg, ty_p_reg);
        pix_next.chroma = chroma_a_reg;
        pix_next.v      = chroma_a_reg ? clamp(cv_p_reg, tv_p_reg) : '0;
        pix_next.u      = chroma_a_reg ? clamp(cu_p_reg, tu_p_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (enb) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_pix   = pix_reg;

endmodule

`default_nettype wire

// ===== tb/sv/thermal_visible_yuv_fusion_test.sv =====
// Self-checking testbench for the thermal/visible YUV fusion block.
`default_nettype none

module thermal_visible_yuv_fusion_test;
    import thvf_pkg::*;

    localparam int COEF_FRAC = COEF_FRAC_BITS_DEF;
    localparam int GAIN_FRAC = GAIN_FRAC_BITS_DEF;

    // BT.601 coefficients, rounded to Q.COEF_FRAC
    localparam int K_YR = (257 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_YG = (504 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_YB = (98 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_UR = (148 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_UG = (291 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_UB = (439 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_VR = (439 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_VG = (368 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int K_VB = (71 * (1 << COEF_FRAC) + 500) / 1000;
    localparam int LUMA_BIAS = 16 - 128;
    localparam int HF_BIAS = 128;
    localparam int GAIN_MAX = (1 << GAIN_W) - 1;

    localparam logic [IDX_W:0] UNMAPPED_FIRST = 4'd5;
    localparam logic [IDX_W:0] UNMAPPED_LAST = 4'd7;

    localparam int RANDOM_PHASES = 6;
    localparam int PIXELS_PER_PHASE = 325;
    localparam int LIMIT_CYCLES = 2000000;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [47:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cfg_t   fuse_cfg;
    fused_t fused_expected[$];
    bit     gap_on = 1'b0;
    bit     stall_on = 1'b0;
    int     stall_left = 0;
    int     errors = 0;
    int     pixels_sent = 0;
    int     chroma_pixels = 0;
    int     beats_checked = 0;
    int     reg_writes = 0;

    thermal_visible_yuv_fusion dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("[thermal_visible_yuv_fusion] ERROR");
        $finish;
    end

    function automatic logic [PIX_W-1:0] blend_clamp(int cam, int cam_gain, int off, int th_gain);
        int acc;
        acc = (cam * cam_gain + off * th_gain) / (1 << GAIN_FRAC);
        if (acc < 0)
            acc = 0;
        if (acc > 255)
            acc = 255;
        return acc[PIX_W-1:0];
    endfunction

    function automatic fused_t fuse_pixel(pix_t p);
        int r, g, b, y_off, u_off, v_off, gy, gc;
        fused_t f;
        r = p.red;
        g = p.green;
        b = p.blue;
        gy = fuse_cfg.hf_mode ? 0 : fuse_cfg.cam_y_gain;
        gc = fuse_cfg.hf_mode ? 0 : fuse_cfg.cam_c_gain;
        y_off = (K_YR * r + K_YG * g + K_YB * b + (LUMA_BIAS << COEF_FRAC)) / (1 << COEF_FRAC);
        u_off = (-K_UR * r - K_UG * g + K_UB * b) / (1 << COEF_FRAC);
        v_off = (K_VR * r - K_VG * g - K_VB * b) / (1 << COEF_FRAC);
        if (fuse_cfg.hf_mode) begin
            y_off += HF_BIAS;
            u_off += HF_BIAS;
            v_off += HF_BIAS;
        end
        f.luma = blend_clamp(p.cam_y, gy, y_off, fuse_cfg.th_y_gain);
        f.chroma = p.chroma;
        f.v = p.chroma ? blend_clamp(p.cam_v, gc, v_off, fuse_cfg.th_c_gain) : '0;
        f.u = p.chroma ? blend_clamp(p.cam_u, gc, u_off, fuse_cfg.th_c_gain) : '0;
        return f;
    endfunction

    function automatic logic [APB_DW-1:0] reg_value(reg_idx_t idx);
        case (idx)
            REG_MODE:       return APB_DW'(fuse_cfg.hf_mode);
            REG_CAM_Y_GAIN: return APB_DW'(fuse_cfg.cam_y_gain);
            REG_CAM_C_GAIN: return APB_DW'(fuse_cfg.cam_c_gain);
            REG_TH_Y_GAIN:  return APB_DW'(fuse_cfg.th_y_gain);
            REG_TH_C_GAIN:  return APB_DW'(fuse_cfg.th_c_gain);
            default:        return '0;
        endcase
    endfunction

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_pause(bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PIX_W-1:0] rand_sample();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? PIX_MAX : '0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic int rand_gain();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? GAIN_MAX : 0;
        return $urandom_range(0, GAIN_MAX);
    endfunction

    function automatic pix_t mk_pixel(int y, int b, int g, int r, bit c, int v, int u);
        pix_t p;
        p.cam_y = PIX_W'(y);
        p.blue = PIX_W'(b);
        p.green = PIX_W'(g);
        p.red = PIX_W'(r);
        p.chroma = c;
        p.cam_v = PIX_W'(v);
        p.cam_u = PIX_W'(u);
        return p;
    endfunction

    function automatic pix_t rand_pixel();
        return mk_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                        1'($urandom_range(0, 1)), rand_sample(), rand_sample());
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left <= pick_pause(1'b1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        fused_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (fused_expected.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %b", m_tdata, m_tuser);
                errors++;
            end else begin
                want = fused_expected.pop_front();
                beats_checked++;
                if (m_tdata[7:0] !== want.luma) begin
                    $error("fused_luma: expected %0d, got %0d", want.luma, m_tdata[7:0]);
                    errors++;
                end
                if (m_tuser !== want.chroma) begin
                    $error("chroma_out_valid: expected %0d, got %0d", want.chroma, m_tuser);
                    errors++;
                end
                if (m_tdata[15:8] !== want.v) begin
                    $error("fused_v: expected %0d, got %0d", want.v, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== want.u) begin
                    $error("fused_u: expected %0d, got %0d", want.u, m_tdata[23:16]);
                    errors++;
                end
            end
        end
    end

    task automatic send_pixel(pix_t p);
        int gap;
        gap = pick_pause(gap_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.cam_u, p.cam_v, p.red, p.green, p.blue, p.cam_y};
        s_tuser <= p.chroma;
        do @(posedge aclk); while (!s_tready);
        fused_expected.push_back(fuse_pixel(p));
        pixels_sent++;
        if (p.chroma)
            chroma_pixels++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (fused_expected.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [APB_DW-1:0] data);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:       fuse_cfg.hf_mode = data[0];
            REG_CAM_Y_GAIN: fuse_cfg.cam_y_gain = data[GAIN_W-1:0];
            REG_CAM_C_GAIN: fuse_cfg.cam_c_gain = data[GAIN_W-1:0];
            REG_TH_Y_GAIN:  fuse_cfg.th_y_gain = data[GAIN_W-1:0];
            REG_TH_C_GAIN:  fuse_cfg.th_c_gain = data[GAIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic reg_read(reg_idx_t idx);
        logic [APB_DW-1:0] want;
        want = reg_value(idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("register %s: expected %0d, got %0d", idx.name(), want, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // upper pwdata bits carry noise; the block must keep only the register width
    task automatic set_config(bit mode, int cy, int cc, int ty, int tc);
        reg_write(REG_MODE, ($urandom() << 1) | APB_DW'(mode));
        reg_write(REG_CAM_Y_GAIN, ($urandom() << GAIN_W) | APB_DW'(cy));
        reg_write(REG_CAM_C_GAIN, ($urandom() << GAIN_W) | APB_DW'(cc));
        reg_write(REG_TH_Y_GAIN, ($urandom() << GAIN_W) | APB_DW'(ty));
        reg_write(REG_TH_C_GAIN, ($urandom() << GAIN_W) | APB_DW'(tc));
        for (int i = 0; i <= REG_TH_C_GAIN; i++)
            reg_read(reg_idx_t'(i));
    endtask

    task automatic test_reset_values();
        for (int i = 0; i <= REG_TH_C_GAIN; i++)
            reg_read(reg_idx_t'(i));
    endtask

    task automatic test_default_blend();
        send_pixel(mk_pixel(0, 0, 0, 0, 1, 0, 0));
        send_pixel(mk_pixel(255, 255, 255, 255, 1, 255, 255));
        send_pixel(mk_pixel(128, 0, 0, 255, 1, 128, 128));
        send_pixel(mk_pixel(0, 0, 255, 0, 1, 0, 0));
        send_pixel(mk_pixel(255, 255, 0, 0, 1, 255, 255));
        // no chroma on this pixel: U and V must come out zero
        send_pixel(mk_pixel(90, 40, 50, 60, 0, 255, 255));
        send_pixel(mk_pixel(255, 0, 0, 0, 0, 0, 0));
        // tiny negative chroma offset truncates toward zero
        send_pixel(mk_pixel(100, 0, 0, 1, 1, 100, 100));
    endtask

    task automatic test_gain_extremes();
        int cam_g, th_g;
        for (int k = 0; k < 4; k++) begin
            cam_g = (k == 1 || k == 2) ? GAIN_MAX : 0;
            th_g = (k == 1 || k == 3) ? GAIN_MAX : 0;
            set_config(1'b0, cam_g, cam_g, th_g, th_g);
            send_pixel(mk_pixel(255, 255, 255, 255, 1, 255, 255));
            send_pixel(mk_pixel(200, 0, 255, 0, 1, 200, 200));
        end
    endtask

    task automatic test_high_frequency();
        set_config(1'b1, GAIN_MAX, GAIN_MAX, int'(GAIN_RST), int'(GAIN_RST));
        send_pixel(mk_pixel(0, 0, 0, 0, 1, 0, 0));
        send_pixel(mk_pixel(255, 255, 255, 255, 1, 255, 255));
        send_pixel(mk_pixel(77, 0, 0, 255, 1, 33, 200));
        send_pixel(mk_pixel(150, 0, 255, 0, 1, 255, 0));
        send_pixel(mk_pixel(10, 255, 0, 0, 1, 0, 255));
        send_pixel(mk_pixel(255, 30, 60, 90, 0, 255, 255));
        // camera gains are only masked in this mode, the stored values remain
        wait_idle();
        reg_read(REG_CAM_Y_GAIN);
        reg_read(REG_CAM_C_GAIN);
    endtask

    task automatic test_register_map();
        set_config(1'b0, 300, 200, 400, 100);
        for (logic [IDX_W:0] a = UNMAPPED_FIRST; a <= UNMAPPED_LAST; a++)
            reg_write(a[IDX_W-1:0], '1);
        for (int i = 0; i <= REG_TH_C_GAIN; i++)
            reg_read(reg_idx_t'(i));
        send_pixel(mk_pixel(120, 200, 30, 180, 1, 60, 220));
        send_pixel(mk_pixel(40, 10, 240, 20, 1, 250, 5));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_config(1'b0, int'(GAIN_RST), int'(GAIN_RST), int'(GAIN_RST), int'(GAIN_RST));
                2, 4: set_config(1'b1, rand_gain(), rand_gain(), rand_gain(), rand_gain());
                3: set_config(1'b0, $urandom_range(0, 1) * GAIN_MAX, $urandom_range(0, 1) * GAIN_MAX,
                              $urandom_range(0, 1) * GAIN_MAX, $urandom_range(0, 1) * GAIN_MAX);
                default: set_config(1'b0, rand_gain(), rand_gain(), rand_gain(), rand_gain());
            endcase
            gap_on = (ph != 1);
            stall_on = (ph != 1) && (ph != 4);
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                send_pixel(rand_pixel());
                // occasional burst with both sides at full rate
                if (n % 100 == 50) begin
                    gap_on = 1'b0;
                    stall_on = 1'b0;
                end else if (n % 100 == 80 && ph != 1) begin
                    gap_on = 1'b1;
                    stall_on = (ph != 4);
                end
            end
        end
        gap_on = 1'b0;
        stall_on = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        fuse_cfg = '{hf_mode: 1'b0, cam_y_gain: GAIN_RST, cam_c_gain: GAIN_RST,
                     th_y_gain: GAIN_RST, th_c_gain: GAIN_RST};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_default_blend();
        test_gain_extremes();
        test_high_frequency();
        test_register_map();
        test_random_traffic();
        wait_idle();

        $display("covered %0d pixel beats (%0d with chroma), %0d result beats checked",
                 pixels_sent, chroma_pixels, beats_checked);
        $display("over %0d register writes: default, extreme, random and high-frequency gains",
                 reg_writes);
        if (errors == 0) begin
            $display("[thermal_visible_yuv_fusion] OK");
        end else begin
            $display("[thermal_visible_yuv_fusion] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
